[hdl/rect_to_polar_degrees_defines.svh]
// Assertion macros used by the checker file of the polar converter.
// Every macro samples on the rising edge of clk and is switched off while arst_n is low.
`ifndef RECT_TO_POLAR_DEGREES_DEFINES_SVH
`define RECT_TO_POLAR_DEGREES_DEFINES_SVH

// The expression must hold at every clock edge outside reset.
`define RTPD_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// When the first expression holds, the second must hold at the same edge.
`define RTPD_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[hdl/rtpd_pkg.sv]
package rtpd_pkg;

	// Widths of the result fields.
	localparam int RADIUS_W = 23;
	localparam int ANGLE_W  = 15;

	// The CORDIC x/y datapath. Its magnitude stays below 2^61 for every input.
	localparam int CORDIC_W = 62;
	// The fraction bits of the x/y datapath are (FRAC_TOP - COORD_WIDTH).
	localparam int FRAC_TOP = 60;

	// The angle accumulator counts units of 1e-9 degree.
	localparam int ZACC_W = 38;
	localparam int ZMAG_W = 37;

	localparam logic signed [ZACC_W-1:0] ATAN_TABLE [0:31] = '{
		38'sd45000000000, 38'sd26565051177, 38'sd14036243468, 38'sd7125016349,
		38'sd3576334375,  38'sd1789910608,  38'sd895173710,   38'sd447614171,
		38'sd223810500,   38'sd111905677,   38'sd55952892,    38'sd27976453,
		38'sd13988227,    38'sd6994114,     38'sd3497057,     38'sd1748528,
		38'sd874264,      38'sd437132,      38'sd218566,      38'sd109283,
		38'sd54642,       38'sd27321,       38'sd13660,       38'sd6830,
		38'sd3415,        38'sd1708,        38'sd854,         38'sd427,
		38'sd213,         38'sd107,         38'sd53,          38'sd27
	};

	// Rounding to hundredths of a degree: (mag + 5e6) / 1e7. The division is done
	// as a shift by 7 followed by a reciprocal multiply for 78125.
	localparam logic signed [ZACC_W-1:0] ROUND_HALF = 38'sd5000000;
	localparam int DIV_PRE_SHIFT = 7;
	localparam int DIV_IN_W      = ZMAG_W - DIV_PRE_SHIFT;
	localparam int RECIP_W       = 31;
	localparam logic [RECIP_W-1:0] RECIP_M = 31'd1801439851;
	localparam int RECIP_SHIFT   = 47;
	localparam int QUOT_W        = 14;
	localparam int PROD_W        = DIV_IN_W + RECIP_W;

	localparam logic [QUOT_W-1:0] ANGLE_LIMIT = 14'd9000;
	localparam logic [RADIUS_W-1:0] RADIUS_MAX = 23'd8388607;

	// Flags that ride along the angle path.
	typedef struct packed {
		logic undef;
		logic xzero;
		logic yneg;
	} pflags_t;

	// Clock cycles from an accepted beat to its result strobe.
	function automatic int rtpd_latency(input int coord_w, input int stages);
		int rad_lat;
		int ang_lat;
		rad_lat = coord_w + 13;
		ang_lat = stages + 4;
		return (rad_lat > ang_lat) ? rad_lat : ang_lat;
	endfunction

endpackage

[hdl/rect_to_polar_degrees.sv]
// Rectangular to polar converter. Each beat on x_coord/y_coord returns the radius
// round(100*sqrt(x*x+y*y)) and the angle round(100*atan(y/x)) in degrees, the
// single-argument arctangent limited to -9000..+9000 hundredths. When x is zero the
// angle is +9000 or -9000 by the sign of y; when both are zero the angle is 0 and
// angle_undefined is set. A beat is taken at a rising edge with start high and busy
// low. busy is high only in reset and the cycle after it, so a new beat can enter
// on every clock. The result appears for one cycle with done high. Its delay is set
// by the longer of two pipelines: the bit-serial square root, one root bit per
// stage over COORD_WIDTH + 7 stages, and the CORDIC vectoring chain with one
// micro-rotation per stage. The receiver cannot stall the block, so no result is
// ever held back and none is dropped.
module rect_to_polar_degrees #(
	parameter int COORD_WIDTH   = 16,
	parameter int CORDIC_STAGES = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [COORD_WIDTH-1:0]         x_coord,
	input  logic signed [COORD_WIDTH-1:0]         y_coord,
	output logic                                  done,
	output logic [rtpd_pkg::RADIUS_W-1:0]         radius_hundredths,
	output logic signed [rtpd_pkg::ANGLE_W-1:0]   angle_hundredths_deg,
	output logic                                  angle_undefined
);
	import rtpd_pkg::*;

	// Widths of the radius path. The square root is taken of N = 10000*(x*x+y*y),
	// so its integer root is already the radius in hundredths before rounding.
	localparam int CW   = COORD_WIDTH;
	localparam int SW   = 2 * CW;
	localparam int NW   = SW + 14;
	localparam int RW   = CW + 7;
	localparam int RSW  = (RW + 1 > RADIUS_W) ? RW + 1 : RADIUS_W;
	localparam int FRAC = FRAC_TOP - CW;

	localparam int LAT   = rtpd_latency(CW, CORDIC_STAGES);
	localparam int PAD_R = LAT - (RW + 6);
	localparam int PAD_A = LAT - (CORDIC_STAGES + 4);

	// A beat is accepted whenever start is high outside the reset window.
	logic accept;
	logic rst_hold_q;

	assign accept = start && !rst_hold_q;
	assign busy   = rst_hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rst_hold_q <= 1'b1;
		end else begin
			rst_hold_q <= 1'b0;
		end
	end

	// Valid bits travel alongside the data. The payload registers load on every
	// clock, since nothing downstream can hold them.
	logic [LAT:1] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[LAT-1:1], accept};
		end
	end

	assign done = vld_s[LAT];

	// ------------------------------------------------------------------
	// Stage 1: sign handling. A negative x mirrors the point through the
	// origin, which leaves y/x unchanged. The magnitudes feed the radius.
	// ------------------------------------------------------------------
	logic signed [CW+1:0] x_ext;
	logic signed [CW+1:0] y_ext;
	logic signed [CW+1:0] x_mir;
	logic signed [CW+1:0] y_mir;
	logic signed [CW+1:0] y_abs;
	logic                 x_neg;
	pflags_t              flags_in;

	assign x_ext = {{2{x_coord[CW-1]}}, x_coord};
	assign y_ext = {{2{y_coord[CW-1]}}, y_coord};
	assign x_neg = x_coord[CW-1];
	assign x_mir = x_neg ? -x_ext : x_ext;
	assign y_mir = x_neg ? -y_ext : y_ext;
	assign y_abs = y_coord[CW-1] ? -y_ext : y_ext;

	assign flags_in.undef = (x_coord == '0) && (y_coord == '0);
	assign flags_in.xzero = (x_coord == '0);
	assign flags_in.yneg  = y_coord[CW-1];

	logic [CW-1:0] ax_s1;
	logic [CW-1:0] ay_s1;

	logic signed [CORDIC_W-1:0] cx_s [0:CORDIC_STAGES];
	logic signed [CORDIC_W-1:0] cy_s [0:CORDIC_STAGES];
	logic signed [ZACC_W-1:0]   z_s  [0:CORDIC_STAGES];
	pflags_t                    flg_s [0:CORDIC_STAGES];

	always_ff @(posedge clk) begin
		ax_s1    <= x_mir[CW-1:0];
		ay_s1    <= y_abs[CW-1:0];
		cx_s[0]  <= {x_mir, {FRAC{1'b0}}};
		cy_s[0]  <= {y_mir, {FRAC{1'b0}}};
		z_s[0]   <= '0;
		flg_s[0] <= flags_in;
	end

	// ------------------------------------------------------------------
	// Radius path, stages 2 to 5: squares, their sum, and the scaling by
	// 10000 = 2^13 + 2^10 + 2^9 + 2^8 + 2^4 split over two adds.
	// ------------------------------------------------------------------
	logic [SW-1:0] sq_x_s2;
	logic [SW-1:0] sq_y_s2;
	logic [SW-1:0] sum_s3;
	logic [NW-1:0] scl_a_s4;
	logic [NW-1:0] scl_b_s4;
	logic [NW-1:0] sum_ext;

	assign sum_ext = NW'(sum_s3);

	always_ff @(posedge clk) begin
		sq_x_s2  <= ax_s1 * ax_s1;
		sq_y_s2  <= ay_s1 * ay_s1;
		sum_s3   <= sq_x_s2 + sq_y_s2;
		scl_a_s4 <= (sum_ext << 13) + (sum_ext << 10);
		scl_b_s4 <= (sum_ext << 9) + (sum_ext << 8) + (sum_ext << 4);
	end

	// Restoring square root: each stage brings down the next two bits of N and
	// decides one root bit.
	logic [NW-1:0]   sqn_s  [0:RW];
	logic [RW+1:0]   rem_s  [0:RW];
	logic [RW-1:0]   root_s [0:RW];

	always_ff @(posedge clk) begin
		sqn_s[0]  <= scl_a_s4 + scl_b_s4;
		rem_s[0]  <= '0;
		root_s[0] <= '0;
	end

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		logic [RW+3:0] trial;
		logic [RW+3:0] subtr;
		logic [RW+4:0] diff;

		assign trial = {rem_s[k], sqn_s[k][NW-1 -: 2]};
		assign subtr = {2'b00, root_s[k], 2'b01};
		assign diff  = {1'b0, trial} - {1'b0, subtr};

		always_ff @(posedge clk) begin
			sqn_s[k+1] <= sqn_s[k] << 2;
			if (!diff[RW+4]) begin
				rem_s[k+1]  <= diff[RW+1:0];
				root_s[k+1] <= {root_s[k][RW-2:0], 1'b1};
			end else begin
				rem_s[k+1]  <= trial[RW+1:0];
				root_s[k+1] <= {root_s[k][RW-2:0], 1'b0};
			end
		end
	end

	// Round to nearest: a remainder above the root means the true root lies past
	// the half. An exact tie cannot occur. Then saturate to the field.
	logic           rad_inc;
	logic [RSW-1:0] rad_sum;
	logic [RADIUS_W-1:0] rad_d [0:PAD_R];

	assign rad_inc = rem_s[RW] > {2'b00, root_s[RW]};
	assign rad_sum = RSW'(root_s[RW]) + RSW'(rad_inc);

	always_ff @(posedge clk) begin
		rad_d[0] <= (rad_sum > RSW'(RADIUS_MAX)) ? RADIUS_MAX : rad_sum[RADIUS_W-1:0];
	end

	for (genvar k = 0; k < PAD_R; k++) begin : g_rad_pad
		always_ff @(posedge clk) begin
			rad_d[k+1] <= rad_d[k];
		end
	end

	assign radius_hundredths = rad_d[PAD_R];

	// ------------------------------------------------------------------
	// Angle path: CORDIC vectoring, one micro-rotation per stage. A stage
	// rotates toward y = 0 and adds or subtracts atan(2^-i) to the angle.
	// The shifts are arithmetic, as the rounding of the result relies on.
	// ------------------------------------------------------------------
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		logic signed [CORDIC_W-1:0] dx;
		logic signed [CORDIC_W-1:0] dy;
		logic                       y_low;

		assign dx    = cy_s[i] >>> i;
		assign dy    = cx_s[i] >>> i;
		assign y_low = cy_s[i][CORDIC_W-1];

		always_ff @(posedge clk) begin
			flg_s[i+1] <= flg_s[i];
			if (!y_low) begin
				cx_s[i+1] <= cx_s[i] + dx;
				cy_s[i+1] <= cy_s[i] - dy;
				z_s[i+1]  <= z_s[i] + ATAN_TABLE[i];
			end else begin
				cx_s[i+1] <= cx_s[i] - dx;
				cy_s[i+1] <= cy_s[i] + dy;
				z_s[i+1]  <= z_s[i] - ATAN_TABLE[i];
			end
		end
	end

	// First post stage: magnitude plus half a hundredth, with the sign kept.
	logic signed [ZACC_W-1:0] z_fin;
	logic signed [ZACC_W-1:0] zrnd;
	logic [ZMAG_W-1:0]        zrnd_sp1;
	logic                     zneg_sp1;
	pflags_t                  flg_sp1;

	assign z_fin = z_s[CORDIC_STAGES];
	assign zrnd  = z_fin[ZACC_W-1] ? (ROUND_HALF - z_fin) : (z_fin + ROUND_HALF);

	always_ff @(posedge clk) begin
		zrnd_sp1 <= zrnd[ZMAG_W-1:0];
		zneg_sp1 <= z_fin[ZACC_W-1];
		flg_sp1  <= flg_s[CORDIC_STAGES];
	end

	// Second post stage: divide by 1e7 as a shift by 7 and a reciprocal multiply
	// that is exact over the whole range of the accumulator.
	logic [PROD_W-1:0] prod_sp2;
	logic              zneg_sp2;
	pflags_t           flg_sp2;

	always_ff @(posedge clk) begin
		prod_sp2 <= zrnd_sp1[ZMAG_W-1:DIV_PRE_SHIFT] * RECIP_M;
		zneg_sp2 <= zneg_sp1;
		flg_sp2  <= flg_sp1;
	end

	// Third post stage: clamp to 90 degrees, restore the sign, and apply the
	// axis and origin cases.
	logic [QUOT_W-1:0]         quot;
	logic [QUOT_W-1:0]         quot_lim;
	logic signed [ANGLE_W-1:0] ang_val;
	logic signed [ANGLE_W-1:0] ang_d [0:PAD_A];
	logic                      und_d [0:PAD_A];

	assign quot     = prod_sp2[RECIP_SHIFT +: QUOT_W];
	assign quot_lim = (quot > ANGLE_LIMIT) ? ANGLE_LIMIT : quot;

	always_comb begin
		if (flg_sp2.undef) begin
			ang_val = '0;
		end else if (flg_sp2.xzero) begin
			ang_val = flg_sp2.yneg ? -ANGLE_W'(ANGLE_LIMIT) : ANGLE_W'(ANGLE_LIMIT);
		end else begin
			ang_val = zneg_sp2 ? -ANGLE_W'(quot_lim) : ANGLE_W'(quot_lim);
		end
	end

	always_ff @(posedge clk) begin
		ang_d[0] <= ang_val;
		und_d[0] <= flg_sp2.undef;
	end

	for (genvar k = 0; k < PAD_A; k++) begin : g_ang_pad
		always_ff @(posedge clk) begin
			ang_d[k+1] <= ang_d[k];
			und_d[k+1] <= und_d[k];
		end
	end

	assign angle_hundredths_deg = ang_d[PAD_A];
	assign angle_undefined      = und_d[PAD_A];

endmodule

[hdl/rtpd_checker.sv]
`include "rect_to_polar_degrees_defines.svh"

module rtpd_checker #(
	parameter int COORD_WIDTH   = 16,
	parameter int CORDIC_STAGES = 24
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic signed [COORD_WIDTH-1:0]       x_coord,
	input logic signed [COORD_WIDTH-1:0]       y_coord,
	input logic                                done,
	input logic [rtpd_pkg::RADIUS_W-1:0]       radius_hundredths,
	input logic signed [rtpd_pkg::ANGLE_W-1:0] angle_hundredths_deg,
	input logic                                angle_undefined
);
	import rtpd_pkg::*;

	localparam int LAT = rtpd_latency(COORD_WIDTH, CORDIC_STAGES);
	localparam logic signed [ANGLE_W-1:0] ANG_HI = ANGLE_W'(ANGLE_LIMIT);
	localparam logic signed [ANGLE_W-1:0] ANG_LO = -ANGLE_W'(ANGLE_LIMIT);

	logic beat;
	logic ang_in_range;
	logic origin_in;
	logic origin_out;

	assign beat         = start && !busy;
	assign ang_in_range = (angle_hundredths_deg <= ANG_HI) && (angle_hundredths_deg >= ANG_LO);
	assign origin_in    = (x_coord == '0) && (y_coord == '0);
	assign origin_out   = (radius_hundredths == '0) && (angle_hundredths_deg == '0);

	// Every accepted beat yields exactly one strobe, a fixed number of cycles later.
	`RTPD_ASSERT_IMPLY(a_strobe_has_beat, done, $past(beat, LAT), "strobe without a beat")
	`RTPD_ASSERT_IMPLY(a_beat_has_strobe, $past(beat, LAT), done, "beat without its strobe")

	`RTPD_ASSERT_IMPLY(a_angle_range, done, ang_in_range, "angle outside 90 degrees")

	`RTPD_ASSERT_IMPLY(a_undef_source, done, angle_undefined == $past(origin_in, LAT), "bad undef flag")

	`RTPD_ASSERT_IMPLY(a_undef_zero, done && angle_undefined, origin_out, "origin result not zero")

endmodule

bind rect_to_polar_degrees rtpd_checker #(
	.COORD_WIDTH(COORD_WIDTH),
	.CORDIC_STAGES(CORDIC_STAGES)
) u_rtpd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.x_coord(x_coord),
	.y_coord(y_coord),
	.done(done),
	.radius_hundredths(radius_hundredths),
	.angle_hundredths_deg(angle_hundredths_deg),
	.angle_undefined(angle_undefined)
);
